// ===== rtl/core/kbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbc_pkg
// Shared types and constants for the keyboard controller scan-code queue.
// ----------------------------------------------------------------------------
package kbc_pkg;

    typedef enum logic [1:0] {
        OP_PORT_READ  = 2'd0,
        OP_PORT_WRITE = 2'd1,
        OP_TIMER_TICK = 2'd2,
        OP_KEY_EVENT  = 2'd3
    } op_t;

    localparam logic [15:0] PORT_DATA   = 16'h0060;
    localparam logic [15:0] PORT_SYSTEM = 16'h0061;
    localparam logic [15:0] PORT_STATUS = 16'h0064;

    localparam logic [7:0] RESET_BITS         = 8'hC0;
    localparam logic [7:0] RESET_CODE         = 8'hAA;
    localparam logic [7:0] SYSTEM_RESET_VALUE = 8'h0E;

    // Status bit positions.
    localparam int unsigned DATA_READY_BIT    = 0;
    localparam int unsigned COMMAND_READY_BIT = 1;

    typedef logic [1:0] status_t;

endpackage

// ===== rtl/core/keyboard_controller_scan_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_controller_scan_queue
// Simplified PC keyboard controller with a scan-code ring buffer in memory.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid / in_stall) carries one transaction per item:
// a port read, a port write, a timer tick or a key event. The output channel
// (out_valid / out_stall) returns exactly one result per item: read_data,
// key_accepted and irq_pulse.
// A result appears in the output register on the cycle after its item is
// accepted. Throughput is one item per cycle while no result is stalled.
// The scan codes live in a synchronous memory whose head entry is fetched
// every cycle at the next head address, with a bypass when a key is written
// to that same entry, so a timer tick always finds the head byte ready.
// While the receiver stalls a pending result, in_stall is raised and the
// result holds; a new item is taken in the same cycle the old result leaves.
// Reset empties the queue, clears the data byte and status, and loads the
// system port byte with 0x0E. Queue memory contents are not cleared; entries
// are only read after they have been written.
// ----------------------------------------------------------------------------
module keyboard_controller_scan_queue #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [15:0] port_addr,
    input  logic [7:0]  write_data,
    input  logic [7:0]  key_code,
    input  logic        force_overwrite,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic        key_accepted,
    output logic        irq_pulse
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SUM_W = CNT_W + 1;
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);

    logic [7:0] queue_mem [QUEUE_DEPTH];

    logic [PTR_W-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [7:0]            data_reg, data_next;
    kbc_pkg::status_t      status_reg, status_next;
    logic [7:0]            system_reg, system_next;
    logic [7:0]            head_byte_reg;

    logic                  out_valid_reg;
    logic [7:0]            read_data_reg, read_data_next;
    logic                  accepted_reg, accepted_next;
    logic                  irq_reg, irq_next;

    logic                  take;
    logic                  wr_en;
    logic [PTR_W-1:0]      wr_addr;
    logic [SUM_W-1:0]      tail_sum;
    logic [PTR_W-1:0]      tail_ptr;
    logic [PTR_W-1:0]      prev_ptr;
    kbc_pkg::op_t          op_code;

    assign in_stall = out_valid_reg && out_stall;
    assign take     = in_valid && !in_stall;
    assign op_code  = kbc_pkg::op_t'(op);

    // Tail slot is (head + count) mod depth; the sum stays below twice the depth.
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_ptr = (tail_sum >= DEPTH_SUM) ? PTR_W'(tail_sum - DEPTH_SUM)
                                              : PTR_W'(tail_sum);
    // Newest entry of a full queue sits just before the head.
    assign prev_ptr = (head_reg == '0) ? LAST_PTR : head_reg - PTR_W'(1);

    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        data_next      = data_reg;
        status_next    = status_reg;
        system_next    = system_reg;
        read_data_next = 8'h00;
        accepted_next  = 1'b0;
        irq_next       = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = tail_ptr;

        if (take)
        begin
            case (op_code)
                kbc_pkg::OP_PORT_READ:
                begin
                    if (port_addr == kbc_pkg::PORT_DATA)
                    begin
                        read_data_next = data_reg;
                        data_next      = 8'h00;
                        status_next    = '0;
                    end
                    else if (port_addr == kbc_pkg::PORT_SYSTEM)
                    begin
                        read_data_next = system_reg;
                    end
                    else if (port_addr == kbc_pkg::PORT_STATUS)
                    begin
                        read_data_next = {6'b0, status_reg};
                    end
                end
                kbc_pkg::OP_PORT_WRITE:
                begin
                    if (port_addr == kbc_pkg::PORT_SYSTEM)
                    begin
                        if ((system_reg & kbc_pkg::RESET_BITS) == 8'h00 &&
                            (write_data & kbc_pkg::RESET_BITS) != 8'h00)
                        begin
                            count_next  = '0;
                            data_next   = kbc_pkg::RESET_CODE;
                            status_next = 2'b11;
                            irq_next    = 1'b1;
                        end
                        system_next = write_data;
                    end
                end
                kbc_pkg::OP_TIMER_TICK:
                begin
                    status_next[kbc_pkg::COMMAND_READY_BIT] = 1'b1;
                    if (count_reg != '0 && !status_reg[kbc_pkg::DATA_READY_BIT])
                    begin
                        status_next[kbc_pkg::DATA_READY_BIT] = 1'b1;
                        data_next  = head_byte_reg;
                        head_next  = (head_reg == LAST_PTR) ? '0 : head_reg + PTR_W'(1);
                        count_next = count_reg - CNT_W'(1);
                        irq_next   = 1'b1;
                    end
                end
                kbc_pkg::OP_KEY_EVENT:
                begin
                    if (count_reg < FULL_CNT)
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = tail_ptr;
                        count_next    = count_reg + CNT_W'(1);
                        accepted_next = 1'b1;
                    end
                    else if (force_overwrite)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = prev_ptr;
                    end
                end
                default:
                begin
                    read_data_next = 8'h00;
                end
            endcase
        end
    end

    // Queue memory: one write port and a registered read of the next head slot.
    // A write to the slot being fetched is forwarded into the head byte.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            queue_mem[wr_addr] <= key_code;
        end
        if (wr_en && wr_addr == head_next)
        begin
            head_byte_reg <= key_code;
        end
        else
        begin
            head_byte_reg <= queue_mem[head_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            data_reg      <= 8'h00;
            status_reg    <= '0;
            system_reg    <= kbc_pkg::SYSTEM_RESET_VALUE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            count_reg  <= count_next;
            data_reg   <= data_next;
            status_reg <= status_next;
            system_reg <= system_next;
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            read_data_reg <= read_data_next;
            accepted_reg  <= accepted_next;
            irq_reg       <= irq_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = read_data_reg;
    assign key_accepted = accepted_reg;
    assign irq_pulse    = irq_reg;

endmodule

// ===== sim/keyboard_controller_scan_queue_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_controller_scan_queue_checker
// Watches both channels of the keyboard controller, keeps a shadow copy of
// its queue, data byte, status and system port byte, and compares every
// returned reply against the reply the shadow state predicts.
// ----------------------------------------------------------------------------
module keyboard_controller_scan_queue_checker #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  op,
    input  logic [15:0] port_addr,
    input  logic [7:0]  write_data,
    input  logic [7:0]  key_code,
    input  logic        force_overwrite,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  read_data,
    input  logic        key_accepted,
    input  logic        irq_pulse,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [7:0] read_data;
        logic       key_accepted;
        logic       irq_pulse;
    } reply_t;

    logic [7:0]        shadow_queue [QUEUE_DEPTH];
    int unsigned       queue_head;
    int unsigned       queue_count;
    logic [7:0]        shadow_data;
    kbc_pkg::status_t  shadow_status;
    logic [7:0]        shadow_system;
    reply_t            reply_q [$];
    int                errors;

    // Applies one transaction to the shadow state and returns its reply.
    function automatic reply_t apply_transaction(kbc_pkg::op_t o, logic [15:0] p,
                                                 logic [7:0] w, logic [7:0] k, logic f);
        reply_t r;
        r = '0;
        case (o)
            kbc_pkg::OP_PORT_READ:
            begin
                if (p == kbc_pkg::PORT_DATA)
                begin
                    r.read_data   = shadow_data;
                    shadow_data   = 8'h00;
                    shadow_status = '0;
                end
                else if (p == kbc_pkg::PORT_SYSTEM)
                    r.read_data = shadow_system;
                else if (p == kbc_pkg::PORT_STATUS)
                    r.read_data = {6'b0, shadow_status};
            end
            kbc_pkg::OP_PORT_WRITE:
            begin
                if (p == kbc_pkg::PORT_SYSTEM)
                begin
                    // Keyboard reset fires only on a rising edge of bits 7:6.
                    if ((shadow_system & kbc_pkg::RESET_BITS) == 8'h00 &&
                        (w & kbc_pkg::RESET_BITS) != 8'h00)
                    begin
                        queue_count                               = 0;
                        shadow_data                               = kbc_pkg::RESET_CODE;
                        shadow_status[kbc_pkg::DATA_READY_BIT]    = 1'b1;
                        shadow_status[kbc_pkg::COMMAND_READY_BIT] = 1'b1;
                        r.irq_pulse                               = 1'b1;
                    end
                    shadow_system = w;
                end
            end
            kbc_pkg::OP_TIMER_TICK:
            begin
                shadow_status[kbc_pkg::COMMAND_READY_BIT] = 1'b1;
                if (queue_count != 0 && !shadow_status[kbc_pkg::DATA_READY_BIT])
                begin
                    shadow_status[kbc_pkg::DATA_READY_BIT] = 1'b1;
                    shadow_data = shadow_queue[queue_head];
                    queue_head  = (queue_head + 1) % QUEUE_DEPTH;
                    queue_count--;
                    r.irq_pulse = 1'b1;
                end
            end
            default:
            begin
                if (queue_count < QUEUE_DEPTH)
                begin
                    shadow_queue[(queue_head + queue_count) % QUEUE_DEPTH] = k;
                    queue_count++;
                    r.key_accepted = 1'b1;
                end
                else if (f)
                    shadow_queue[(queue_head + QUEUE_DEPTH - 1) % QUEUE_DEPTH] = k;
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
                shadow_queue[i] = 8'h00;
            queue_head    = 0;
            queue_count   = 0;
            shadow_data   = 8'h00;
            shadow_status = '0;
            shadow_system = kbc_pkg::SYSTEM_RESET_VALUE;
            reply_q.delete();
            errors        = 0;
            fail_count   <= 0;
            pending      <= 0;
        end
        else
        begin
            // A reply leaving now belongs to an earlier transaction, so check it first.
            if (out_valid && !out_stall)
            begin
                if (reply_q.size() == 0)
                begin
                    $error("reply with no transaction waiting: read_data %0h", read_data);
                    errors++;
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (read_data !== want.read_data)
                    begin
                        $error("read_data: expected %0h, actual %0h",
                               want.read_data, read_data);
                        errors++;
                    end
                    if (key_accepted !== want.key_accepted)
                    begin
                        $error("key_accepted: expected %0b, actual %0b",
                               want.key_accepted, key_accepted);
                        errors++;
                    end
                    if (irq_pulse !== want.irq_pulse)
                    begin
                        $error("irq_pulse: expected %0b, actual %0b",
                               want.irq_pulse, irq_pulse);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                reply_q.push_back(apply_transaction(kbc_pkg::op_t'(op), port_addr,
                                                    write_data, key_code,
                                                    force_overwrite));
            fail_count <= errors;
            pending    <= reply_q.size();
        end
    end

endmodule

// ===== sim/keyboard_controller_scan_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_controller_scan_queue_tb
// Drives port reads, port writes, timer ticks and key events into the
// keyboard controller with random gaps and random result stalls. A directed
// pass covers port decoding, keyboard reset and a full queue; random typing,
// draining and system port sequences follow. The checker judges each reply.
// ----------------------------------------------------------------------------
module keyboard_controller_scan_queue_tb;

    localparam int unsigned DEPTH       = 16;
    localparam int unsigned ITEM_TARGET = 700;
    localparam int unsigned CYCLE_LIMIT = 300000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  op;
    logic [15:0] port_addr;
    logic [7:0]  write_data;
    logic [7:0]  key_code;
    logic        force_overwrite;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  read_data;
    logic        key_accepted;
    logic        irq_pulse;
    int          fail_count;
    int          pending;

    int unsigned cycle_count;
    int unsigned items_sent;
    bit          tx_burst;
    bit          rx_burst;

    keyboard_controller_scan_queue #(.QUEUE_DEPTH(DEPTH)) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .port_addr       (port_addr),
        .write_data      (write_data),
        .key_code        (key_code),
        .force_overwrite (force_overwrite),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .read_data       (read_data),
        .key_accepted    (key_accepted),
        .irq_pulse       (irq_pulse)
    );

    keyboard_controller_scan_queue_checker #(.QUEUE_DEPTH(DEPTH)) reply_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .port_addr       (port_addr),
        .write_data      (write_data),
        .key_code        (key_code),
        .force_overwrite (force_overwrite),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .read_data       (read_data),
        .key_accepted    (key_accepted),
        .irq_pulse       (irq_pulse),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Presents one transaction after a random gap and holds it until taken.
    task automatic send_item(kbc_pkg::op_t o, logic [15:0] p, logic [7:0] w, logic [7:0] k,
                             logic f);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        op              <= o;
        port_addr       <= p;
        write_data      <= w;
        key_code        <= k;
        force_overwrite <= f;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    task automatic do_read(logic [15:0] p);
        send_item(kbc_pkg::OP_PORT_READ, p, 8'($urandom()), 8'($urandom()), 1'($urandom()));
    endtask

    task automatic do_write(logic [15:0] p, logic [7:0] w);
        send_item(kbc_pkg::OP_PORT_WRITE, p, w, 8'($urandom()), 1'($urandom()));
    endtask

    task automatic do_tick();
        send_item(kbc_pkg::OP_TIMER_TICK, 16'($urandom()), 8'($urandom()), 8'($urandom()),
                  1'($urandom()));
    endtask

    task automatic do_key(logic [7:0] k, logic f);
        send_item(kbc_pkg::OP_KEY_EVENT, 16'($urandom()), 8'($urandom()), k, f);
    endtask

    // Result side: a random stall ahead of every reply, with stall-free stretches.
    initial
    begin : result_side
        int unsigned hold;
        rx_burst  = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rx_burst = !rx_burst;
            hold = rx_burst ? 0 : $urandom_range(0, 13);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    initial
    begin : stimulus
        int unsigned n;
        logic [7:0]  w;
        items_sent      = 0;
        tx_burst        = 1'b0;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        op              = kbc_pkg::OP_PORT_READ;
        port_addr       = 16'h0000;
        write_data      = 8'h00;
        key_code        = 8'h00;
        force_overwrite = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: port decode, tick rules, full queue, keyboard reset.
        do_read(kbc_pkg::PORT_STATUS);
        do_read(kbc_pkg::PORT_SYSTEM);
        do_read(kbc_pkg::PORT_DATA);
        do_read(16'h0000);
        do_read(16'hFFFF);
        do_tick();
        do_key(8'h00, 1'b0);
        do_key(8'hFF, 1'b1);
        do_tick();
        do_tick();
        do_read(kbc_pkg::PORT_STATUS);
        do_read(kbc_pkg::PORT_DATA);
        for (int i = 0; i < DEPTH - 1; i++)
            do_key(8'($urandom()), 1'($urandom()));
        do_key(8'h5A, 1'b1);
        do_key(8'hA5, 1'b0);
        do_tick();
        do_read(kbc_pkg::PORT_DATA);
        do_write(16'hFFFF, 8'hFF);
        do_write(kbc_pkg::PORT_SYSTEM, 8'h40);
        do_read(kbc_pkg::PORT_DATA);
        do_tick();
        do_write(kbc_pkg::PORT_SYSTEM, 8'hC0);
        do_write(kbc_pkg::PORT_SYSTEM, 8'h3F);
        do_write(kbc_pkg::PORT_SYSTEM, 8'h80);
        do_read(kbc_pkg::PORT_SYSTEM);

        // Random: typing bursts, draining, system port activity and noise.
        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    n = $urandom_range(1, 20);
                    repeat (n) do_key(8'($urandom()), 1'($urandom()));
                end
                4, 5, 6:
                begin
                    n = $urandom_range(1, 8);
                    repeat (n)
                    begin
                        do_tick();
                        if ($urandom_range(0, 2) == 0)
                            do_read(kbc_pkg::PORT_STATUS);
                        do_read(kbc_pkg::PORT_DATA);
                    end
                end
                7:
                begin
                    w = 8'($urandom());
                    if ($urandom_range(0, 1) == 1)
                        w[7:6] = 2'b00;
                    do_write(kbc_pkg::PORT_SYSTEM, w);
                    do_write(kbc_pkg::PORT_SYSTEM, 8'($urandom()));
                end
                8:
                begin
                    do_read(kbc_pkg::PORT_SYSTEM);
                    do_read(kbc_pkg::PORT_STATUS);
                end
                default:
                begin
                    n = $urandom_range(1, 4);
                    repeat (n)
                        send_item(kbc_pkg::op_t'($urandom_range(0, 3)),
                                  ($urandom_range(0, 3) == 0) ? kbc_pkg::PORT_SYSTEM
                                                              : 16'($urandom()),
                                  8'($urandom()), 8'($urandom()), 1'($urandom()));
                end
            endcase
        end
        in_valid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/kbc_pkg.sv
rtl/core/keyboard_controller_scan_queue.sv
sim/keyboard_controller_scan_queue_checker.sv
sim/keyboard_controller_scan_queue_tb.sv
